// File: sv/lzwe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW encoder package
// Beat payload types and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lzwe_pkg;

    localparam int unsigned SEED_COUNT = 256;
    localparam int unsigned MAX_RESET  = 4096;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } lzwe_in_t;

    typedef struct packed {
        logic [11:0] code_word;
        logic [3:0]  code_width;
        logic        stream_end;
        logic        run_last;
    } lzwe_out_t;

    typedef struct packed {
        logic accept;
        logic first_byte;
        logic scan_start;
        logic scan_read;
        logic scan_next;
        logic take_match;
        logic emit;
        logic emit_end;
        logic emit_run_last;
        logic learn;
        logic prefix_byte;
        logic clear_prefix;
    } lzwe_cmd_t;

    typedef struct packed {
        logic prefix_valid;
        logic last;
        logic scan_done;
        logic match;
        logic out_free;
    } lzwe_status_t;

endpackage

// File: sv/lzw_variable_width_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variable-width encoder core
// Turns a byte stream into LZW code words with their bit widths.
// ----------------------------------------------------------------------------
// A byte beat with no prefix held loads the prefix, and flushes it if last.
// Otherwise the controller scans the learned entries one at a time through
// the single registered read port of the dictionary memory, a read state
// then a compare state per entry, stops early on a match and emits a code word
// on a miss and at stream end. A new byte is taken only once the last one is
// handled. Output stalls hold the controller only while the result register is full.
module lzw_variable_width_encoder_core #(
    parameter int CODE_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lzwe_pkg::lzwe_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lzwe_pkg::lzwe_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [12:0]         cfg_data
);
    import lzwe_pkg::*;

    lzwe_cmd_t    cmd;
    lzwe_status_t status;
    logic [12:0]  max_entries_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= 13'(MAX_RESET);
        end else if (cfg_valid) begin
            max_entries_reg <= cfg_data;
        end
    end

    lzwe_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lzwe_datapath #(
        .CODE_BITS (CODE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .max_entries (max_entries_reg),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// File: sv/lzwe_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW encoder datapath
// Dictionary memory, prefix and count registers, scan pointer and the
// output register.
// ----------------------------------------------------------------------------
module lzwe_datapath #(
    parameter int CODE_BITS = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  lzwe_pkg::lzwe_in_t s_data,
    input  logic [12:0]        max_entries,
    input  lzwe_pkg::lzwe_cmd_t  cmd,
    output lzwe_pkg::lzwe_status_t status,
    output logic               m_valid,
    input  logic               m_ready,
    output lzwe_pkg::lzwe_out_t m_data
);
    import lzwe_pkg::*;

    localparam int CW    = CODE_BITS + 1;
    localparam int KW    = CODE_BITS + 8;
    localparam int LW    = (CW > 13) ? CW : 13;
    localparam int DEPTH = 1 << CODE_BITS;

    logic [KW-1:0]        mem [DEPTH];
    logic [KW-1:0]        rdata_reg;
    logic [7:0]           byte_reg;
    logic                 last_reg;
    logic [CODE_BITS-1:0] prefix_reg;
    logic                 pvalid_reg;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        k_reg;
    logic                 m_valid_reg;
    lzwe_out_t            out_reg;

    logic [KW-1:0]        key;
    logic [LW-1:0]        max_ext;
    logic [LW-1:0]        lim_ext;
    logic [CW-1:0]        limit;
    logic [CW-1:0]        cm1;
    logic [4:0]           width;
    logic [CODE_BITS+11:0] code_ext;

    assign key     = {prefix_reg, byte_reg};
    assign max_ext = LW'(max_entries);
    assign cm1     = count_reg - CW'(1);
    assign code_ext = {12'b0, prefix_reg};

    always_comb begin
        if (max_ext < LW'(SEED_COUNT)) begin
            lim_ext = LW'(SEED_COUNT);
        end else if (max_ext > LW'(DEPTH)) begin
            lim_ext = LW'(DEPTH);
        end else begin
            lim_ext = max_ext;
        end
    end
    assign limit = lim_ext[CW-1:0];

    always_comb begin
        width = '0;
        for (int i = 0; i < CW; i++) begin
            if (cm1[i]) begin
                width = 5'(i + 1);
            end
        end
    end

    assign status.prefix_valid = pvalid_reg;
    assign status.last         = last_reg;
    assign status.scan_done    = (k_reg == count_reg);
    assign status.match        = (rdata_reg == key);
    assign status.out_free     = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (cmd.scan_read) begin
            rdata_reg <= mem[k_reg[CODE_BITS-1:0]];
        end
        if (cmd.learn && count_reg < limit) begin
            mem[count_reg[CODE_BITS-1:0]] <= key;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            byte_reg <= s_data.data_byte;
            last_reg <= s_data.last_byte;
        end
        if (cmd.emit) begin
            out_reg.code_word     <= code_ext[11:0];
            out_reg.code_width    <= width[3:0];
            out_reg.stream_end    <= cmd.emit_end;
            out_reg.run_last      <= cmd.emit_run_last;
        end
        if (!aresetn) begin
            prefix_reg  <= '0;
            pvalid_reg  <= 1'b0;
            count_reg   <= CW'(SEED_COUNT);
            k_reg       <= CW'(SEED_COUNT);
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.first_byte || cmd.prefix_byte) begin
                prefix_reg <= CODE_BITS'(byte_reg);
                pvalid_reg <= 1'b1;
            end
            if (cmd.take_match) begin
                prefix_reg <= k_reg[CODE_BITS-1:0];
            end
            if (cmd.clear_prefix) begin
                prefix_reg <= '0;
                pvalid_reg <= 1'b0;
            end
            if (cmd.learn && count_reg < limit) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.scan_start) begin
                k_reg <= CW'(SEED_COUNT);
            end else if (cmd.scan_next) begin
                k_reg <= k_reg + CW'(1);
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// File: sv/lzwe_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW encoder controller
// Sequences accept, dictionary scan, miss handling and flush.
// ----------------------------------------------------------------------------
module lzwe_controller (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  lzwe_pkg::lzwe_status_t status,
    output lzwe_pkg::lzwe_cmd_t    cmd
);
    import lzwe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FIRST, ST_READ, ST_CMP, ST_MISS, ST_FLUSH
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    if (status.prefix_valid) begin
                        cmd.scan_start = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_FIRST;
                    end
                end
            end
            ST_FIRST: begin
                cmd.first_byte = 1'b1;
                state_next = status.last ? ST_FLUSH : ST_IDLE;
            end
            ST_READ: begin
                if (status.scan_done) begin
                    state_next = ST_MISS;
                end else begin
                    cmd.scan_read = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (status.match) begin
                    cmd.take_match = 1'b1;
                    state_next = status.last ? ST_FLUSH : ST_IDLE;
                end else begin
                    cmd.scan_next = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_MISS: begin
                if (status.out_free) begin
                    cmd.emit          = 1'b1;
                    cmd.emit_run_last = !status.last;
                    cmd.learn         = 1'b1;
                    cmd.prefix_byte   = 1'b1;
                    state_next = status.last ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (status.out_free) begin
                    cmd.emit          = 1'b1;
                    cmd.emit_end      = 1'b1;
                    cmd.emit_run_last = 1'b1;
                    cmd.clear_prefix  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZW variable-width encoder testbench
// Sends byte streams through the encoder with random gaps and output stalls,
// and checks every code word, width and end flag against a dictionary model
// kept in the testbench. The dictionary limit is changed between phases.
// ----------------------------------------------------------------------------
module tb;
    import lzwe_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned DEPTH       = 4096;

    typedef struct {
        logic [7:0]  data_byte;
        logic        last_byte;
        bit          typed;
        logic [11:0] code_word;
        logic [3:0]  code_width;
    } stim_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    lzwe_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    lzwe_out_t m_data;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic [12:0] cfg_data = '0;

    logic [19:0] dict_pairs [0:DEPTH-1];
    int unsigned dict_count;
    int unsigned dict_limit;
    logic [11:0] held_prefix;
    bit          held_valid;
    lzwe_out_t   code_queue [$];

    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned burst_left = 0;

    stim_row_t directed [] = '{
        '{8'h00, 1'b1, 1'b1, 12'h000, 4'd8},
        '{8'hFF, 1'b1, 1'b1, 12'h0FF, 4'd8},
        '{8'h41, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h42, 1'b0, 1'b1, 12'h041, 4'd8},
        '{8'h41, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h42, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h41, 1'b1, 1'b0, 12'h000, 4'd0},
        '{8'h41, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h42, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h41, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h42, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h41, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h42, 1'b1, 1'b0, 12'h000, 4'd0},
        '{8'hFF, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h00, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'hFF, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'h00, 1'b1, 1'b0, 12'h000, 4'd0},
        '{8'h55, 1'b0, 1'b0, 12'h000, 4'd0},
        '{8'hAA, 1'b1, 1'b0, 12'h000, 4'd0},
        '{8'h80, 1'b1, 1'b0, 12'h000, 4'd0}
    };

    int unsigned limit_steps [] = '{270, 0, 8191, 4096, 256};

    lzw_variable_width_encoder_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [3:0] code_bits(int unsigned count);
        int unsigned span;
        int unsigned bits;
        span = count - 1;
        bits = 0;
        while (bits < 31 && (span >> bits) != 0) bits++;
        return bits[3:0];
    endfunction

    task automatic push_code(logic [11:0] code, logic stream_end);
        lzwe_out_t code_beat;
        code_beat.code_word  = code;
        code_beat.code_width = code_bits(dict_count);
        code_beat.stream_end = stream_end;
        code_beat.run_last   = 1'b0;
        code_queue.push_back(code_beat);
    endtask

    // Returns the number of code words this byte emits.
    task automatic encode_byte(logic [7:0] data_byte, logic last_byte, output int emitted);
        logic [19:0] pair;
        int unsigned idx;
        bit hit;
        emitted = 0;
        if (!held_valid) begin
            held_prefix = {4'd0, data_byte};
            held_valid  = 1'b1;
        end else begin
            pair = {held_prefix, data_byte};
            hit = 1'b0;
            for (idx = 256; idx < dict_count; idx++) begin
                if (dict_pairs[idx] == pair) begin
                    hit = 1'b1;
                    break;
                end
            end
            if (hit) begin
                held_prefix = idx[11:0];
            end else begin
                push_code(held_prefix, 1'b0);
                emitted++;
                if (dict_count < dict_limit) begin
                    dict_pairs[dict_count] = pair;
                    dict_count++;
                end
                held_prefix = {4'd0, data_byte};
            end
        end
        if (last_byte) begin
            push_code(held_prefix, 1'b1);
            emitted++;
            held_prefix = '0;
            held_valid  = 1'b0;
        end
        if (emitted > 0) begin
            code_queue[code_queue.size()-1].run_last = 1'b1;
        end
    endtask

    task automatic report(string field, int unsigned got, int unsigned want);
        $display("mismatch on %s at cycle %0d: got %0d, expected %0d",
                 field, cycles, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (code_queue.size() == 0) begin
                report("unexpected beat", m_data.code_word, 0);
            end else begin
                lzwe_out_t want;
                want = code_queue.pop_front();
                if (m_data.code_word !== want.code_word)
                    report("code_word", m_data.code_word, want.code_word);
                if (m_data.code_width !== want.code_width)
                    report("code_width", m_data.code_width, want.code_width);
                if (m_data.stream_end !== want.stream_end)
                    report("stream_end", m_data.stream_end, want.stream_end);
                if (m_data.run_last !== want.run_last)
                    report("run_last", m_data.run_last, want.run_last);
            end
        end
    end

    // The receiver steps through four stall patterns in turn.
    always @(posedge aclk) begin
        case ((cycles / 300) % 4)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 1) == 1);
            end
            2: begin
                m_ready <= ($urandom_range(0, 3) == 0);
            end
            default: begin
                m_ready <= ((cycles % 8) < 5);
            end
        endcase
    end

    task automatic send_byte(logic [7:0] data_byte, logic last_byte, output int emitted);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data.data_byte <= data_byte;
        s_data.last_byte <= last_byte;
        do @(posedge aclk); while (!s_ready);
        encode_byte(data_byte, last_byte, emitted);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (code_queue.size() != 0) @(posedge aclk);
        repeat (2 * dict_count + 40) @(posedge aclk);
    endtask

    task automatic write_limit(logic [12:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (value < 256) dict_limit = 256;
        else if (value > DEPTH) dict_limit = DEPTH;
        else dict_limit = value;
    endtask

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'(8'h61 + $urandom_range(0, 3));
    endfunction

    initial begin
        int emitted;
        int unsigned stream_len;
        int unsigned pos;
        logic [7:0] data_byte;
        logic last_byte;
        dict_count  = 256;
        dict_limit  = DEPTH;
        held_prefix = '0;
        held_valid  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[row]) begin
            send_byte(directed[row].data_byte, directed[row].last_byte, emitted);
            if (directed[row].typed && emitted == 1) begin
                code_queue[code_queue.size()-1].code_word  = directed[row].code_word;
                code_queue[code_queue.size()-1].code_width = directed[row].code_width;
            end
        end
        drain();

        foreach (limit_steps[phase]) begin
            write_limit(13'(limit_steps[phase]));
            pos = 0;
            while (pos < 80) begin
                stream_len = $urandom_range(1, 14);
                for (int unsigned k = 0; k < stream_len; k++) begin
                    data_byte = pick_byte();
                    last_byte = (k == stream_len - 1) && ($urandom_range(0, 7) != 0);
                    send_byte(data_byte, last_byte, emitted);
                    pos++;
                end
            end
            // Close any open stream so the next phase starts cleanly.
            send_byte(pick_byte(), 1'b1, emitted);
            drain();
        end

        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
